@@ rtl/pnd_pkg.sv @@
// Shared defaults, request codes and the gradient selection table of the noise block.
`timescale 1ns / 1ps
`default_nettype none

package pnd_pkg;

	localparam int TABLE_SIZE_DEF = 256;
	localparam int FRAC_BITS_DEF  = 16;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_EVAL = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		COEF_ZERO = 2'd0,
		COEF_POS  = 2'd1,
		COEF_NEG  = 2'd2
	} coef_t;

	typedef struct packed {
		coef_t cx;
		coef_t cy;
		coef_t cz;
	} grad_sel_t;

	typedef enum logic [3:0] {
		GRAD_PXPY   = 4'd0,
		GRAD_NXPY   = 4'd1,
		GRAD_PXNY   = 4'd2,
		GRAD_NXNY   = 4'd3,
		GRAD_PXPZ   = 4'd4,
		GRAD_NXPZ   = 4'd5,
		GRAD_PXNZ   = 4'd6,
		GRAD_NXNZ   = 4'd7,
		GRAD_PYPZ   = 4'd8,
		GRAD_NYPZ   = 4'd9,
		GRAD_PYNZ   = 4'd10,
		GRAD_NYNZ   = 4'd11,
		GRAD_PXPY_B = 4'd12,
		GRAD_NXPY_B = 4'd13,
		GRAD_NYPZ_B = 4'd14,
		GRAD_NYNZ_B = 4'd15
	} grad_code_t;

	// Signs applied to the corner offsets for each gradient.
	function automatic grad_sel_t grad_sel(input grad_code_t code);
		grad_sel_t s;
		unique case (code)
			GRAD_PXPY:   s = '{COEF_POS,  COEF_POS,  COEF_ZERO};
			GRAD_NXPY:   s = '{COEF_NEG,  COEF_POS,  COEF_ZERO};
			GRAD_PXNY:   s = '{COEF_POS,  COEF_NEG,  COEF_ZERO};
			GRAD_NXNY:   s = '{COEF_NEG,  COEF_NEG,  COEF_ZERO};
			GRAD_PXPZ:   s = '{COEF_POS,  COEF_ZERO, COEF_POS};
			GRAD_NXPZ:   s = '{COEF_NEG,  COEF_ZERO, COEF_POS};
			GRAD_PXNZ:   s = '{COEF_POS,  COEF_ZERO, COEF_NEG};
			GRAD_NXNZ:   s = '{COEF_NEG,  COEF_ZERO, COEF_NEG};
			GRAD_PYPZ:   s = '{COEF_ZERO, COEF_POS,  COEF_POS};
			GRAD_NYPZ:   s = '{COEF_ZERO, COEF_NEG,  COEF_POS};
			GRAD_PYNZ:   s = '{COEF_ZERO, COEF_POS,  COEF_NEG};
			GRAD_NYNZ:   s = '{COEF_ZERO, COEF_NEG,  COEF_NEG};
			GRAD_PXPY_B: s = '{COEF_POS,  COEF_POS,  COEF_ZERO};
			GRAD_NXPY_B: s = '{COEF_NEG,  COEF_POS,  COEF_ZERO};
			GRAD_NYPZ_B: s = '{COEF_ZERO, COEF_NEG,  COEF_POS};
			GRAD_NYNZ_B: s = '{COEF_ZERO, COEF_NEG,  COEF_NEG};
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

@@ rtl/perlin_noise_3d_with_gradient.sv @@
// Top level of the 3D gradient noise block with analytic partial derivatives.
// Throughput: one request per cycle; the pipeline never stalls downstream.
// A table load request waits (busy) while a noise request that was taken
// in the cycle before sits in the first stage, so earlier hashes still read the old table contents.
// Reset clears the valid bits only; the permutation table is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module perlin_noise_3d_with_gradient
	import pnd_pkg::*;
#(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic [7:0]         entry_index,
	input  logic [7:0]         entry_value,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	output logic               done,
	output logic [16:0]        noise_value,
	output logic signed [19:0] slope_x,
	output logic signed [19:0] slope_y,
	output logic signed [19:0] slope_z
);

	localparam int F   = FRAC_BITS;
	localparam int TW  = $clog2(TABLE_SIZE);
	localparam int FW  = F + 6;
	localparam int WW  = F + 10;
	localparam int RW  = WW + 8;
	localparam int NSH = F - 15;
	localparam int DSH = F - 16;
	localparam logic signed [WW-1:0]   QONE = WW'(64'd1 << F);
	localparam logic signed [2*WW-1:0] HALF = (2*WW)'(64'd1 << (F - 1));

	// Rounded product of two values in the working fixed-point format.
	function automatic logic signed [WW-1:0] mulq(input logic signed [WW-1:0] a,
			input logic signed [WW-1:0] b);
		logic signed [2*WW-1:0] p;
		p = a * b + HALF;
		return WW'(p >>> F);
	endfunction

	function automatic logic signed [WW-1:0] coef_term(input coef_t c,
			input logic signed [WW-1:0] val);
		unique case (c)
			COEF_POS: return val;
			COEF_NEG: return -val;
			default:  return '0;
		endcase
	endfunction

	// Positive n divides by 2^n rounding half up; otherwise multiplies by 2^-n.
	function automatic logic signed [RW-1:0] rescale(input logic signed [WW-1:0] v,
			input int n);
		logic signed [RW-1:0] e;
		e = RW'(v);
		if (n > 0) begin
			e = (e + (RW'(1) <<< (n - 1))) >>> n;
		end else begin
			e = e <<< (-n);
		end
		return e;
	endfunction

	function automatic logic [16:0] sat_unit(input logic signed [RW-1:0] r);
		priority if (r < RW'(0)) begin
			return '0;
		end else if (r > RW'(65536)) begin
			return 17'd65536;
		end else begin
			return r[16:0];
		end
	endfunction

	function automatic logic signed [19:0] sat_slope(input logic signed [RW-1:0] r);
		priority if (r < RW'(-524288)) begin
			return 20'sh80000;
		end else if (r > RW'(524287)) begin
			return 20'sh7FFFF;
		end else begin
			return r[19:0];
		end
	endfunction

	// Request handshake. A load must not overtake the level-three read of the
	// noise request that sits in the first stage.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic acc, acc_eval, acc_load;

	assign busy     = (func == FUNC_LOAD) && vld_s1;
	assign acc      = start && !busy;
	assign acc_eval = acc && (func == FUNC_EVAL);
	assign acc_load = acc && (func == FUNC_LOAD);

	// Cell coordinates: floor of the point, wrapped to the table size.
	logic [31+TW:0] ext_x, ext_y, ext_z;
	logic [TW-1:0]  cx0, cx1, cy0, cy1, cz0, cz1;

	assign ext_x = {{TW{coord_x[31]}}, coord_x};
	assign ext_y = {{TW{coord_y[31]}}, coord_y};
	assign ext_z = {{TW{coord_z[31]}}, coord_z};
	assign cx0   = ext_x[F+TW-1:F];
	assign cy0   = ext_y[F+TW-1:F];
	assign cz0   = ext_z[F+TW-1:F];
	assign cx1   = cx0 + TW'(1);
	assign cy1   = cy0 + TW'(1);
	assign cz1   = cz0 + TW'(1);

	logic [F-1:0]  tx_s1, ty_s1, tz_s1, tx_s2, ty_s2, tz_s2, tx_s3, ty_s3, tz_s3;
	logic [TW-1:0] cy0_s1, cy1_s1, cz0_s1, cz1_s1, cz0_s2, cz1_s2;

	always_ff @(posedge clk) begin
		tx_s1  <= coord_x[F-1:0];
		ty_s1  <= coord_y[F-1:0];
		tz_s1  <= coord_z[F-1:0];
		cy0_s1 <= cy0;
		cy1_s1 <= cy1;
		cz0_s1 <= cz0;
		cz1_s1 <= cz1;
		tx_s2  <= tx_s1;
		ty_s2  <= ty_s1;
		tz_s2  <= tz_s1;
		cz0_s2 <= cz0_s1;
		cz1_s2 <= cz1_s1;
		tx_s3  <= tx_s2;
		ty_s3  <= ty_s2;
		tz_s3  <= tz_s2;
	end

	// Corner hashing: the x level is read at acceptance, y after stage one and
	// z after stage two, so the gradient codes line up with stage three.
	logic [7:0][3:0] codes_s3;

	pnd_hash #(.TABLE_SIZE(TABLE_SIZE)) u_hash (
		.clk(clk),
		.wr_en(acc_load),
		.wr_addr(TW'(entry_index)),
		.wr_data(entry_value),
		.x0(cx0), .x1(cx1),
		.y0(cy0_s1), .y1(cy1_s1),
		.z0(cz0_s2), .z1(cz1_s2),
		.codes(codes_s3)
	);

	// Fade weights and slopes run alongside the hash, ready at stage five.
	logic signed [FW-1:0] fu, fv, fw, gsx, gsy, gsz;

	pnd_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (.clk(clk), .t(tx_s1), .fval(fu), .fslope(gsx));
	pnd_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (.clk(clk), .t(ty_s1), .fval(fv), .fslope(gsy));
	pnd_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_z (.clk(clk), .t(tz_s1), .fval(fw), .fslope(gsz));

	// Stage four: dot product of each corner gradient with its offset vector.
	logic signed [WW-1:0] ox0, ox1, oy0, oy1, oz0, oz1;
	logic signed [WW-1:0] dot_c [8];
	logic signed [WW-1:0] g_s4 [8];

	assign ox0 = $signed(WW'(tx_s3));
	assign oy0 = $signed(WW'(ty_s3));
	assign oz0 = $signed(WW'(tz_s3));
	assign ox1 = ox0 - QONE;
	assign oy1 = oy0 - QONE;
	assign oz1 = oz0 - QONE;

	always_comb begin
		grad_sel_t sel;
		for (int k = 0; k < 8; k++) begin
			sel = grad_sel(grad_code_t'(codes_s3[k]));
			dot_c[k] = coef_term(sel.cx, k[0] ? ox1 : ox0)
				+ coef_term(sel.cy, k[1] ? oy1 : oy0)
				+ coef_term(sel.cz, k[2] ? oz1 : oz0);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 8; k++) begin
			g_s4[k] <= dot_c[k];
		end
	end

	// Stage five: trilinear coefficients. Corners are ordered x, then y, then z.
	logic signed [WW-1:0] k_s5 [8];
	logic signed [WW-1:0] k_s6 [8];
	logic signed [WW-1:0] u_s5, v_s5, w_s5, fsx_s5, fsy_s5, fsz_s5;

	assign u_s5   = WW'(fu);
	assign v_s5   = WW'(fv);
	assign w_s5   = WW'(fw);
	assign fsx_s5 = WW'(gsx);
	assign fsy_s5 = WW'(gsy);
	assign fsz_s5 = WW'(gsz);

	always_ff @(posedge clk) begin
		k_s5[0] <= g_s4[0];
		k_s5[1] <= g_s4[1] - g_s4[0];
		k_s5[2] <= g_s4[2] - g_s4[0];
		k_s5[3] <= g_s4[4] - g_s4[0];
		k_s5[4] <= g_s4[0] + g_s4[3] - g_s4[1] - g_s4[2];
		k_s5[5] <= g_s4[0] + g_s4[5] - g_s4[1] - g_s4[4];
		k_s5[6] <= g_s4[0] + g_s4[6] - g_s4[2] - g_s4[4];
		k_s5[7] <= g_s4[1] + g_s4[2] + g_s4[4] + g_s4[7]
			- g_s4[0] - g_s4[3] - g_s4[5] - g_s4[6];
	end

	// Stage six: first round of products with the fade weights.
	logic signed [WW-1:0] t1_s6, t2_s6, t3_s6, uv_s6, uw_s6, vw_s6, w_s6;
	logic signed [WW-1:0] pxv_s6, pxw_s6, pyu_s6, pyw_s6, pzu_s6, pzv_s6;
	logic signed [WW-1:0] fsx_s6, fsy_s6, fsz_s6;

	always_ff @(posedge clk) begin
		t1_s6  <= mulq(k_s5[1], u_s5);
		t2_s6  <= mulq(k_s5[2], v_s5);
		t3_s6  <= mulq(k_s5[3], w_s5);
		uv_s6  <= mulq(u_s5, v_s5);
		uw_s6  <= mulq(u_s5, w_s5);
		vw_s6  <= mulq(v_s5, w_s5);
		pxv_s6 <= mulq(k_s5[4], v_s5);
		pxw_s6 <= mulq(k_s5[5], w_s5);
		pyu_s6 <= mulq(k_s5[4], u_s5);
		pyw_s6 <= mulq(k_s5[6], w_s5);
		pzu_s6 <= mulq(k_s5[5], u_s5);
		pzv_s6 <= mulq(k_s5[6], v_s5);
		w_s6   <= w_s5;
		fsx_s6 <= fsx_s5;
		fsy_s6 <= fsy_s5;
		fsz_s6 <= fsz_s5;
		for (int k = 0; k < 8; k++) begin
			k_s6[k] <= k_s5[k];
		end
	end

	// Stage seven: products with the cross terms and the first partial sums.
	logic signed [WW-1:0] uvw_s7, q4_s7, q5_s7, q6_s7, rx_s7, ry_s7, rz_s7;
	logic signed [WW-1:0] part_s7, ix_s7, iy_s7, iz_s7, k7_s7;
	logic signed [WW-1:0] fsx_s7, fsy_s7, fsz_s7;

	always_ff @(posedge clk) begin
		uvw_s7  <= mulq(uv_s6, w_s6);
		q4_s7   <= mulq(k_s6[4], uv_s6);
		q5_s7   <= mulq(k_s6[5], uw_s6);
		q6_s7   <= mulq(k_s6[6], vw_s6);
		rx_s7   <= mulq(k_s6[7], vw_s6);
		ry_s7   <= mulq(k_s6[7], uw_s6);
		rz_s7   <= mulq(k_s6[7], uv_s6);
		part_s7 <= k_s6[0] + t1_s6 + t2_s6 + t3_s6;
		ix_s7   <= k_s6[1] + pxv_s6 + pxw_s6;
		iy_s7   <= k_s6[2] + pyu_s6 + pyw_s6;
		iz_s7   <= k_s6[3] + pzu_s6 + pzv_s6;
		k7_s7   <= k_s6[7];
		fsx_s7  <= fsx_s6;
		fsy_s7  <= fsy_s6;
		fsz_s7  <= fsz_s6;
	end

	// Stage eight: last noise product, completed derivative brackets.
	logic signed [WW-1:0] q7_s8, part_s8, dx_s8, dy_s8, dz_s8;
	logic signed [WW-1:0] fsx_s8, fsy_s8, fsz_s8;

	always_ff @(posedge clk) begin
		q7_s8   <= mulq(k7_s7, uvw_s7);
		part_s8 <= part_s7 + q4_s7 + q5_s7 + q6_s7;
		dx_s8   <= ix_s7 + rx_s7;
		dy_s8   <= iy_s7 + ry_s7;
		dz_s8   <= iz_s7 + rz_s7;
		fsx_s8  <= fsx_s7;
		fsy_s8  <= fsy_s7;
		fsz_s8  <= fsz_s7;
	end

	// Stage nine: noise sum and the scaling by the fade slopes.
	logic signed [WW-1:0] sum_s9, gx_s9, gy_s9, gz_s9;

	always_ff @(posedge clk) begin
		sum_s9 <= part_s8 + q7_s8;
		gx_s9  <= mulq(fsx_s8, dx_s8);
		gy_s9  <= mulq(fsy_s8, dy_s8);
		gz_s9  <= mulq(fsz_s8, dz_s8);
	end

	// Stage ten: map the noise to [0,1], rescale to 16 fraction bits, saturate.
	logic [16:0]        noise_s10;
	logic signed [19:0] sx_s10, sy_s10, sz_s10;

	always_ff @(posedge clk) begin
		noise_s10 <= sat_unit(rescale(sum_s9 + QONE, NSH));
		sx_s10    <= sat_slope(rescale(gx_s9, DSH));
		sy_s10    <= sat_slope(rescale(gy_s9, DSH));
		sz_s10    <= sat_slope(rescale(gz_s9, DSH));
	end

	// Valid bits follow each noise request down the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			vld_s1  <= acc_eval;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	assign done        = vld_s10;
	assign noise_value = noise_s10;
	assign slope_x     = sx_s10;
	assign slope_y     = sy_s10;
	assign slope_z     = sz_s10;

	// A table load never lands while a noise request still has a table read ahead.
	a_load_order: assert property (@(posedge clk) disable iff (!arst_n)
		acc_load |-> !vld_s1)
		else $error("table load accepted ahead of a pending hash read");

	// Every accepted noise request gives its result, with done, at the end of the pipeline.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc_eval |-> ##10 done)
		else $error("noise result missing after ten cycles");

	// The mapped noise value never leaves the unit range.
	a_noise_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (noise_value <= 17'd65536))
		else $error("noise value above one");

endmodule

`default_nettype wire

@@ rtl/pnd_ram.sv @@
// Permutation memory copy with one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module pnd_ram #(
	parameter int DEPTH = 256,
	parameter int DW = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [DW-1:0] rdata0,
	output logic [DW-1:0] rdata1
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd0_q;
	logic [DW-1:0] rd1_q;

	// Reads return the contents from before a write at the same edge.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd0_q <= mem[raddr0];
		rd1_q <= mem[raddr1];
	end

	assign rdata0 = rd0_q;
	assign rdata1 = rd1_q;

endmodule

`default_nettype wire

@@ rtl/pnd_hash.sv @@
// Three-level corner hash through replicated copies of the permutation table.
`timescale 1ns / 1ps
`default_nettype none

module pnd_hash #(
	parameter int TABLE_SIZE = 256,
	localparam int TW = $clog2(TABLE_SIZE)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [TW-1:0]    wr_addr,
	input  logic [7:0]       wr_data,
	input  logic [TW-1:0]    x0,
	input  logic [TW-1:0]    x1,
	input  logic [TW-1:0]    y0,
	input  logic [TW-1:0]    y1,
	input  logic [TW-1:0]    z0,
	input  logic [TW-1:0]    z1,
	output logic [7:0][3:0]  codes
);

	// x addresses arrive with the request, y with the level-one read data and z with the level-two read data.
	logic [7:0]    l1 [2];
	logic [7:0]    l2 [4];
	logic [7:0]    l3 [8];
	logic [TW-1:0] ad2 [4];
	logic [TW-1:0] ad3 [8];

	pnd_ram #(.DEPTH(TABLE_SIZE), .DW(8)) u_ram_l1 (
		.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
		.raddr0(x0), .raddr1(x1), .rdata0(l1[0]), .rdata1(l1[1])
	);

	for (genvar i = 0; i < 2; i++) begin : g_l2
		assign ad2[i]     = TW'(l1[i]) + y0;
		assign ad2[i + 2] = TW'(l1[i]) + y1;
		pnd_ram #(.DEPTH(TABLE_SIZE), .DW(8)) u_ram_l2 (
			.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
			.raddr0(ad2[i]), .raddr1(ad2[i + 2]), .rdata0(l2[i]), .rdata1(l2[i + 2])
		);
	end

	for (genvar j = 0; j < 4; j++) begin : g_l3
		assign ad3[j]     = TW'(l2[j]) + z0;
		assign ad3[j + 4] = TW'(l2[j]) + z1;
		pnd_ram #(.DEPTH(TABLE_SIZE), .DW(8)) u_ram_l3 (
			.clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
			.raddr0(ad3[j]), .raddr1(ad3[j + 4]), .rdata0(l3[j]), .rdata1(l3[j + 4])
		);
	end

	for (genvar k = 0; k < 8; k++) begin : g_code
		assign codes[k] = l3[k][3:0];
	end

endmodule

`default_nettype wire

@@ rtl/pnd_fade.sv @@
// Quintic fade curve and its slope for one axis, four register stages deep.
`timescale 1ns / 1ps
`default_nettype none

module pnd_fade #(
	parameter int FRAC_BITS = 16,
	localparam int W = FRAC_BITS + 6
) (
	input  logic                 clk,
	input  logic [FRAC_BITS-1:0] t,
	output logic signed [W-1:0]  fval,
	output logic signed [W-1:0]  fslope
);

	localparam int F = FRAC_BITS;
	localparam logic signed [W-1:0]   QONE = W'(64'd1 << F);
	localparam logic signed [W-1:0]   C6   = W'(6);
	localparam logic signed [W-1:0]   C15Q = W'(64'd15 << F);
	localparam logic signed [W-1:0]   C10Q = W'(64'd10 << F);
	localparam logic signed [2*W-1:0] HALF = (2*W)'(64'd1 << (F - 1));

	function automatic logic signed [W-1:0] mulq(input logic signed [W-1:0] a,
			input logic signed [W-1:0] b);
		logic signed [2*W-1:0] p;
		p = a * b + HALF;
		return W'(p >>> F);
	endfunction

	logic signed [W-1:0] ts;
	logic signed [W-1:0] m1_s2, sq_s2, t_s2;
	logic signed [W-1:0] m2_s3, ss_s3, t_s3;
	logic signed [W-1:0] m3_s4, fs_s4, t_s4;
	logic signed [W-1:0] u_s5, fs_s5;

	assign ts = $signed(W'(t));

	always_ff @(posedge clk) begin
		m1_s2 <= mulq(ts, ts * C6 - C15Q) + C10Q;
		sq_s2 <= mulq(ts, QONE - ts);
		t_s2  <= ts;
		m2_s3 <= mulq(t_s2, m1_s2);
		ss_s3 <= mulq(sq_s2, sq_s2);
		t_s3  <= t_s2;
		m3_s4 <= mulq(t_s3, m2_s3);
		fs_s4 <= (ss_s3 <<< 5) - (ss_s3 <<< 1);
		t_s4  <= t_s3;
		u_s5  <= mulq(t_s4, m3_s4);
		fs_s5 <= fs_s4;
	end

	assign fval   = u_s5;
	assign fslope = fs_s5;

endmodule

`default_nettype wire
